// File: rtl/ist_pkg.sv
// ist_pkg: shared types and constants for the interval set table
// no dependencies
package ist_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request
      logic clr_scan;   // reset scan index; with load, also the scan accumulators
      logic scan_step;  // evaluate one entry, advance index
      logic commit_add;
      logic rm_step;    // rewrite one entry for remove, advance index
      logic rm_split;   // write the split-off piece
      logic set_rsp;    // latch result
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic       last;     // scan index at final entry
      logic       is_empty; // lo >= hi
      logic [1:0] op;
      logic       add_full;
      logic       rm_full;
      logic       need_split;
   } stat_type;

endpackage

// File: rtl/ist_if.sv
// ist_stream_if: valid/ready channel carrying a payload struct
// depends on nothing
interface ist_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ist_ctrl.sv
// ist_ctrl: sequencer for the interval set table
// depends on ist_pkg
module ist_ctrl import ist_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output ctrl_type ctrl
);
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_DEC   = 6'b000100,
      S_RM    = 6'b001000,
      S_SPLIT = 6'b010000,
      S_RSP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);

   always_comb begin
      state_in = state_ff;
      ctrl = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               ctrl.clr_scan = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if ((stat.op == OP_ADD || stat.op == OP_REMOVE) && stat.is_empty) begin
               ctrl.set_rsp = 1'b1;
               state_in = S_RSP;
            end else if (stat.op == OP_ADD || stat.op == OP_REMOVE || stat.op == OP_QUERY) begin
               ctrl.scan_step = 1'b1;
               if (stat.last) state_in = S_DEC;
            end else begin
               ctrl.set_rsp = 1'b1;
               state_in = S_RSP;
            end
         end
         S_DEC: begin
            priority if (stat.op == OP_ADD) begin
               if (!stat.add_full) ctrl.commit_add = 1'b1;
               ctrl.set_rsp = 1'b1;
               state_in = S_RSP;
            end else if (stat.op == OP_REMOVE && !stat.rm_full) begin
               ctrl.clr_scan = 1'b1;
               state_in = S_RM;
            end else begin
               ctrl.set_rsp = 1'b1;
               state_in = S_RSP;
            end
         end
         S_RM: begin
            ctrl.rm_step = 1'b1;
            if (stat.last) state_in = stat.need_split ? S_SPLIT : S_RSP;
            if (stat.last && !stat.need_split) ctrl.set_rsp = 1'b1;
         end
         S_SPLIT: begin
            ctrl.rm_split = 1'b1;
            ctrl.set_rsp = 1'b1;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

// File: rtl/ist_dp.sv
// ist_dp: entry table and scan datapath, one entry per cycle
// depends on ist_pkg
module ist_dp import ist_pkg::*; #(
   parameter int MAX_RANGES = 16,
   parameter int COORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_span_low,
   input  logic [31:0] req_span_high,
   input  ctrl_type    ctrl,
   output stat_type    stat,
   output logic        rsp_covered,
   output logic [1:0]  rsp_status
);
   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int RW = (COORD_BITS < 32) ? COORD_BITS : 32;

   logic [COORD_BITS-1:0] start_ff [MAX_RANGES];
   logic [COORD_BITS-1:0] end_ff [MAX_RANGES];
   logic [MAX_RANGES-1:0] valid_ff;

   logic [1:0] op_ff;
   logic [COORD_BITS-1:0] lo_ff, hi_ff, nlo_ff, nhi_ff, ny_ff;
   logic [IW-1:0] idx_ff;
   logic hits_ff, free_ff, cov_ff, split_ff;
   logic [IW-1:0] slot_ff;
   logic [MAX_RANGES-1:0] merge_ff;
   logic covered_ff;
   logic [1:0] status_ff;

   logic [COORD_BITS-1:0] x, y, lo_in, hi_in;
   logic v, touch, overlap, strict;

   always_comb begin
      lo_in = '0;
      hi_in = '0;
      lo_in[RW-1:0] = req_span_low[RW-1:0];
      hi_in[RW-1:0] = req_span_high[RW-1:0];
   end

   assign x = start_ff[idx_ff];
   assign y = end_ff[idx_ff];
   assign v = valid_ff[idx_ff];
   assign touch = v && !(hi_ff < x || lo_ff > y);
   assign overlap = v && !(hi_ff <= x || lo_ff >= y);
   assign strict = v && x < lo_ff && hi_ff < y;

   assign stat.last = (idx_ff == IW'(MAX_RANGES - 1));
   assign stat.is_empty = (lo_ff >= hi_ff);
   assign stat.op = op_ff;
   // with merges the first merged slot frees up after invalidation
   assign stat.add_full = !hits_ff && !free_ff;
   assign stat.rm_full = split_ff && !free_ff;
   assign stat.need_split = split_ff;

   assign rsp_covered = covered_ff;
   assign rsp_status = status_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         op_ff <= req_opcode;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (ctrl.clr_scan) begin
         idx_ff <= '0;
         if (ctrl.load) begin
            nlo_ff <= lo_in;
            nhi_ff <= hi_in;
            hits_ff <= 1'b0;
            free_ff <= 1'b0;
            cov_ff <= 1'b0;
            split_ff <= 1'b0;
            merge_ff <= '0;
         end
      end else if (ctrl.scan_step) begin
         idx_ff <= idx_ff + 1'b1;
         if (!v && !free_ff) begin
            free_ff <= 1'b1;
            slot_ff <= idx_ff;
         end
         // merged entries count as free only for add
         if (touch && op_ff == OP_ADD) begin
            if (!free_ff) begin
               slot_ff <= idx_ff;
               free_ff <= 1'b1;
            end
            hits_ff <= 1'b1;
            merge_ff[idx_ff] <= 1'b1;
            if (x < nlo_ff) nlo_ff <= x;
            if (y > nhi_ff) nhi_ff <= y;
         end
         if (v && x <= lo_ff && y >= hi_ff) cov_ff <= 1'b1;
         if (strict && !split_ff) begin
            split_ff <= 1'b1;
            ny_ff <= y;
         end
      end else if (ctrl.rm_step) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (ctrl.set_rsp) begin
         covered_ff <= (op_ff == OP_QUERY) && cov_ff && ctrl.set_rsp && !ctrl.load;
         priority if ((op_ff == OP_ADD || op_ff == OP_REMOVE) && lo_ff >= hi_ff)
            status_ff <= ST_EMPTY;
         else if (op_ff == OP_ADD && !hits_ff && !free_ff)
            status_ff <= ST_FULL;
         else if (op_ff == OP_REMOVE && split_ff && !free_ff)
            status_ff <= ST_FULL;
         else
            status_ff <= ST_OK;
      end
      if (ctrl.commit_add) begin
         start_ff[slot_ff] <= nlo_ff;
         end_ff[slot_ff] <= nhi_ff;
      end
      if (ctrl.rm_step && overlap) begin
         if (strict || x < lo_ff) end_ff[idx_ff] <= lo_ff;
         else if (!(lo_ff <= x && y <= hi_ff)) start_ff[idx_ff] <= hi_ff;
      end
      if (ctrl.rm_split) begin
         start_ff[slot_ff] <= hi_ff;
         end_ff[slot_ff] <= ny_ff;
      end
   end

   // slot_ff is the lowest free index after merged entries are dropped
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else begin
         if (ctrl.commit_add) valid_ff <= (valid_ff & ~merge_ff) | (MAX_RANGES'(1) << slot_ff);
         if (ctrl.rm_step && overlap && lo_ff <= x && y <= hi_ff) valid_ff[idx_ff] <= 1'b0;
         if (ctrl.rm_split) valid_ff[slot_ff] <= 1'b1;
      end
   end
endmodule

// File: rtl/interval_set_table.sv
// interval_set_table: bounded table of disjoint half-open intervals
// one request at a time; rate set by the one-entry-per-cycle scan over the table and by response back-pressure
// reset clears the valid map at once; no clearing pass
// depends on ist_pkg, ist_ctrl, ist_dp
module interval_set_table import ist_pkg::*; #(
   parameter int MAX_RANGES = 16,
   parameter int COORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_span_low,
   input  logic [31:0] req_span_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_covered,
   output logic [1:0]  rsp_status
);
   ctrl_type ctrl;
   stat_type stat;

   ist_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .ctrl
   );

   ist_dp #(.MAX_RANGES(MAX_RANGES), .COORD_BITS(COORD_BITS)) u_dp (
      .clock, .reset, .req_opcode, .req_span_low, .req_span_high,
      .ctrl, .stat, .rsp_covered, .rsp_status
   );
endmodule

// File: rtl/ist_checker.sv
// ist_checker: port-level checks for interval_set_table, bound to the top
// depends on ist_pkg
module ist_checker import ist_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_covered,
   input logic [1:0] rsp_status
);
   a_not_both: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped");
   a_cov: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_covered |-> rsp_status == ST_OK) else $error("bad covered");
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
endmodule

bind interval_set_table ist_checker u_chk (.*);

// File: dv/tb.sv
// tb: self-checking testbench for interval_set_table
// depends on ist_pkg, ist_stream_if (rtl/ist_if.sv) and interval_set_table
`timescale 1ns / 100ps

module tb;
   import ist_pkg::*;

   localparam int ENTRIES = 16;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] span_low;
      logic [31:0] span_high;
   } span_req_t;

   typedef struct packed {
      logic       covered;
      logic [1:0] status;
   } span_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   ist_stream_if #(.payload_type(span_req_t)) req_ch (clock);
   ist_stream_if #(.payload_type(span_rsp_t)) rsp_ch (clock);

   interval_set_table u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_opcode    (req_ch.data.opcode),
      .req_span_low  (req_ch.data.span_low),
      .req_span_high (req_ch.data.span_high),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_covered   (rsp_ch.data.covered),
      .rsp_status    (rsp_ch.data.status)
   );

   // shadow copy of the table
   logic [31:0] shadow_start [ENTRIES];
   logic [31:0] shadow_end   [ENTRIES];
   logic        shadow_used  [ENTRIES];

   span_rsp_t pending_rsp [$];
   int  n_mismatch = 0;
   int  n_sent = 0;
   int  n_checked = 0;
   int  n_full = 0;
   int  n_covered = 0;
   longint cycle_count = 0;
   bit  calm = 1'b0;
   int  hold_cycles = 0;

   function automatic int free_entry();
      for (int i = 0; i < ENTRIES; i++)
         if (!shadow_used[i]) return i;
      return -1;
   endfunction

   function automatic logic [1:0] table_add(logic [31:0] lo, logic [31:0] hi);
      int hits;
      int slot;
      logic [31:0] m_lo;
      logic [31:0] m_hi;
      logic touch [ENTRIES];
      hits = 0;
      m_lo = lo;
      m_hi = hi;
      for (int i = 0; i < ENTRIES; i++) begin
         touch[i] = shadow_used[i] && !(hi < shadow_start[i] || lo > shadow_end[i]);
         if (touch[i]) begin
            hits++;
            if (shadow_start[i] < m_lo) m_lo = shadow_start[i];
            if (shadow_end[i] > m_hi) m_hi = shadow_end[i];
         end
      end
      if (hits == 0 && free_entry() < 0) return ST_FULL;
      for (int i = 0; i < ENTRIES; i++)
         if (touch[i]) shadow_used[i] = 1'b0;
      slot = free_entry();
      shadow_start[slot] = m_lo;
      shadow_end[slot] = m_hi;
      shadow_used[slot] = 1'b1;
      return ST_OK;
   endfunction

   function automatic logic [1:0] table_remove(logic [31:0] lo, logic [31:0] hi);
      int slot;
      logic [31:0] x;
      logic [31:0] y;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (shadow_used[i] && shadow_start[i] < lo && hi < shadow_end[i]) begin
            slot = free_entry();
            if (slot < 0) return ST_FULL;
            break;
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (!shadow_used[i]) continue;
         x = shadow_start[i];
         y = shadow_end[i];
         if (hi <= x || lo >= y) continue;
         if (x < lo && hi < y) begin
            shadow_end[i] = lo;
            if (slot >= 0) begin
               shadow_start[slot] = hi;
               shadow_end[slot] = y;
               shadow_used[slot] = 1'b1;
            end
         end else if (lo <= x && y <= hi) begin
            shadow_used[i] = 1'b0;
         end else if (x < lo) begin
            shadow_end[i] = lo;
         end else begin
            shadow_start[i] = hi;
         end
      end
      return ST_OK;
   endfunction

   function automatic span_rsp_t table_apply(span_req_t rq);
      span_rsp_t r;
      r = '0;
      if (rq.opcode == OP_ADD || rq.opcode == OP_REMOVE) begin
         if (rq.span_low >= rq.span_high) r.status = ST_EMPTY;
         else if (rq.opcode == OP_ADD) r.status = table_add(rq.span_low, rq.span_high);
         else r.status = table_remove(rq.span_low, rq.span_high);
      end else if (rq.opcode == OP_QUERY) begin
         for (int i = 0; i < ENTRIES; i++)
            if (shadow_used[i] && shadow_start[i] <= rq.span_low
                && shadow_end[i] >= rq.span_high) r.covered = 1'b1;
      end
      return r;
   endfunction

   // predict on each request transfer, check on each response transfer
   always @(posedge clock) begin
      span_rsp_t want;
      cycle_count <= cycle_count + 1;
      if (!reset && req_ch.valid && req_ch.ready)
         pending_rsp.push_back(table_apply(req_ch.data));
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with nothing expected: covered=%0d status=%0d",
                   rsp_ch.data.covered, rsp_ch.data.status);
            n_mismatch++;
         end else begin
            want = pending_rsp.pop_front();
            n_checked++;
            if (want.status == ST_FULL) n_full++;
            if (want.covered) n_covered++;
            if (rsp_ch.data.covered !== want.covered) begin
               $error("covered: expected %0d actual %0d", want.covered, rsp_ch.data.covered);
               n_mismatch++;
            end
            if (rsp_ch.data.status !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp_ch.data.status);
               n_mismatch++;
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // response side: random stalls (always ready while calm), or a long hold-off when requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
      end
   end

   task automatic send_span(logic [1:0] op, logic [31:0] lo, logic [31:0] hi);
      int gap;
      gap = 0;
      @(negedge clock);
      if (!calm && $urandom_range(99) < 25) gap = $urandom_range(4, 1);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= '{opcode: op, span_low: lo, span_high: hi};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      n_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2 * ENTRIES + 10) @(posedge clock);
   endtask

   task automatic test_basic();
      send_span(OP_ADD, 32'd10, 32'd20);
      send_span(OP_QUERY, 32'd10, 32'd20);
      send_span(OP_QUERY, 32'd5, 32'd20);
      send_span(OP_QUERY, 32'd15, 32'd15);     // empty span inside an entry
      send_span(OP_QUERY, 32'd100, 32'd100);   // empty span outside
      send_span(OP_ADD, 32'd20, 32'd30);       // touching, merges
      send_span(OP_QUERY, 32'd10, 32'd30);
      send_span(OP_REMOVE, 32'd12, 32'd14);    // split
      send_span(OP_REMOVE, 32'd25, 32'd40);    // trims the end
      send_span(OP_ADD, 32'd5, 32'd5);         // empty add
      send_span(OP_REMOVE, 32'd9, 32'd3);      // empty remove
      send_span(OP_UNUSED, 32'd0, 32'hffff_ffff);
      send_span(OP_REMOVE, 32'd0, 32'd100);
      send_span(OP_ADD, 32'd0, 32'hffff_ffff);
      send_span(OP_QUERY, 32'd0, 32'hffff_ffff);
      send_span(OP_REMOVE, 32'd1, 32'hffff_fffe);
      send_span(OP_REMOVE, 32'd0, 32'hffff_ffff);
   endtask

   task automatic test_table_full();
      for (int i = 0; i < ENTRIES; i++)
         send_span(OP_ADD, 32'(i * 10), 32'(i * 10 + 5));
      send_span(OP_ADD, 32'd500, 32'd501);     // no free entry
      send_span(OP_REMOVE, 32'd1, 32'd2);      // split with no free entry
      send_span(OP_ADD, 32'd5, 32'd10);        // merge still allowed
      send_span(OP_REMOVE, 32'd0, 32'hffff_ffff);
   endtask

   task automatic send_random_span();
      logic [1:0]  op;
      logic [31:0] lo;
      logic [31:0] hi;
      int pick;
      pick = $urandom_range(99);
      op = (pick < 40) ? OP_ADD : (pick < 70) ? OP_REMOVE : (pick < 97) ? OP_QUERY : OP_UNUSED;
      if ($urandom_range(99) < 8) begin
         lo = $urandom();
         hi = $urandom();
      end else begin
         lo = $urandom_range(300);
         hi = ($urandom_range(99) < 8) ? lo - $urandom_range(3) : lo + $urandom_range(40);
      end
      if ($urandom_range(99) < 3) begin
         op = OP_REMOVE;
         lo = 32'd0;
         hi = 32'hffff_ffff;
      end
      send_span(op, lo, hi);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         calm = (i >= 300 && i < 420);
         send_random_span();
      end
      calm = 1'b0;
   endtask

   task automatic test_backpressure();
      @(negedge clock);
      hold_cycles = 300;
      for (int i = 0; i < 6; i++) send_random_span();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      for (int i = 0; i < ENTRIES; i++) shadow_used[i] = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic();
      test_table_full();
      wait_drained();
      test_random(400);
      test_backpressure();
      wait_drained();
      test_random(450);
      wait_drained();

      $display("sent %0d requests, checked %0d responses", n_sent, n_checked);
      $display("table-full responses %0d, covered queries %0d", n_full, n_covered);
      if (n_mismatch == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
